FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/lpht_pkg.sv
package lpht_pkg;

   localparam int ID_W            = 31;
   localparam int PAY_W           = 64;
   localparam int SLOT_OUT_W      = 5;
   localparam int ID_MODULUS      = 1000;
   localparam int MOD_W           = $clog2(ID_MODULUS);
   localparam int HASH_SHIFT      = ID_W + MOD_W;
   localparam longint HASH_RECIP  = ((longint'(1) << HASH_SHIFT) + longint'(ID_MODULUS) - 1)
                                    / longint'(ID_MODULUS);
   localparam int TABLE_SLOTS_DEF = 17;
   localparam int REQ_DATA_W      = 160;
   localparam int RSP_DATA_W      = 168;
   localparam int RSP_PAD_W       = RSP_DATA_W - (SLOT_OUT_W + ID_W + 2 * PAY_W);

   typedef enum logic {
      ACT_INSERT,
      ACT_LOOKUP
   } action_type;

   typedef enum logic [1:0] {
      STS_INSERTED,
      STS_FULL,
      STS_FOUND,
      STS_NOT_FOUND
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH_MUL,
      S_HASH_SUB,
      S_SLOT_MUL,
      S_SLOT_SUB,
      S_PROBE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              used;
      logic [ID_W-1:0]   key;
      logic [PAY_W-1:0]  name;
      logic [PAY_W-1:0]  course;
   } entry_type;

endpackage

FILE: rtl/lpht_ram.sv
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/linear_probe_hash_table_unit.sv
// Sequence: an accepted item passes through HASH_MUL, HASH_SUB, SLOT_MUL and SLOT_SUB,
//   then PROBE for each probed slot (1..TABLE_SLOTS); the result is held until taken.
// A new item is taken only after the last result has been taken; the hash and slot
//   steps share one multiplier, and the table has one RAM read port.
// Reset: synchronous, clears control state, then a clearing pass over all TABLE_SLOTS
//   slots empties the table before the first item is taken.
`include "assert_macros.svh"

module linear_probe_hash_table_unit #(
   parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,   // action
   input  logic [lpht_pkg::REQ_DATA_W-1:0] req_tdata,   // student_id, name_chars, course_chars
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [1:0]                      rsp_tuser,   // status
   output logic [lpht_pkg::RSP_DATA_W-1:0] rsp_tdata    // slot_index, found_id, found_name,
                                                        // found_course
);

   localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int ID_W       = lpht_pkg::ID_W;
   localparam int PAY_W      = lpht_pkg::PAY_W;
   localparam int MOD_W      = lpht_pkg::MOD_W;
   localparam int ENTRY_W    = $bits(lpht_pkg::entry_type);
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int QUO_W      = ID_W - MOD_W + 1;
   localparam int HASH_SHIFT = lpht_pkg::HASH_SHIFT;
   localparam int SLOT_SHIFT = MOD_W + SLOT_W;
   localparam longint SLOT_RECIP = ((longint'(1) << SLOT_SHIFT) + longint'(TABLE_SLOTS) - 1)
                                   / longint'(TABLE_SLOTS);

   localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(TABLE_SLOTS - 1);
   localparam logic [MUL_W-1:0]  HASH_RECIP_C = MUL_W'(lpht_pkg::HASH_RECIP);
   localparam logic [MUL_W-1:0]  SLOT_RECIP_C = MUL_W'(SLOT_RECIP);
   localparam logic [MUL_W-1:0]  ID_MOD_C     = MUL_W'(lpht_pkg::ID_MODULUS);
   localparam logic [MUL_W-1:0]  SLOTS_C      = MUL_W'(TABLE_SLOTS);

   lpht_pkg::state_type  state_ff, state_in;
   lpht_pkg::action_type action_ff, action_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [PAY_W-1:0]     name_ff, name_in;
   logic [PAY_W-1:0]     course_ff, course_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [MOD_W-1:0]     hash_ff, hash_in;
   logic [SLOT_W-1:0]    pos_ff, pos_in;
   logic [SLOT_W-1:0]    cnt_ff, cnt_in;

   lpht_pkg::status_type         res_status_ff, res_status_in;
   logic [lpht_pkg::SLOT_OUT_W-1:0] res_slot_ff, res_slot_in;
   logic [ID_W-1:0]              res_id_ff, res_id_in;
   logic [PAY_W-1:0]             res_name_ff, res_name_in;
   logic [PAY_W-1:0]             res_course_ff, res_course_in;

   logic                 ram_we;
   lpht_pkg::entry_type  ram_wdata;
   logic [ENTRY_W-1:0]   ram_rdata;
   lpht_pkg::entry_type  rd_entry;

   logic [MUL_W-1:0]     mul_a;
   logic [MUL_W-1:0]     mul_b;
   logic [PROD_W-1:0]    mul_p;
   logic [ID_W-1:0]      hash_diff;
   logic [MOD_W-1:0]     slot_diff;
   logic                 slot_free;
   logic                 key_hit;
   logic                 last_probe;
   logic                 probe_end;
   logic [SLOT_W-1:0]    pos_next;
   logic                 req_take;
   logic                 in_hash;
   logic                 in_probe;

   lpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff),
      .wr_data (ram_wdata),
      .rd_addr (pos_in),
      .rd_data (ram_rdata)
   );

   assign rd_entry = lpht_pkg::entry_type'(ram_rdata);

   // shared multiplier: reciprocal step, then quotient times divisor for the remainder
   always_comb begin
      unique case (state_ff)
         lpht_pkg::S_HASH_SUB: begin
            mul_a = MUL_W'(quo_ff);
            mul_b = ID_MOD_C;
         end
         lpht_pkg::S_SLOT_MUL: begin
            mul_a = MUL_W'(hash_ff);
            mul_b = SLOT_RECIP_C;
         end
         lpht_pkg::S_SLOT_SUB: begin
            mul_a = MUL_W'(quo_ff);
            mul_b = SLOTS_C;
         end
         default: begin
            mul_a = MUL_W'(id_ff);
            mul_b = HASH_RECIP_C;
         end
      endcase
   end

   assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign hash_diff = id_ff - mul_p[ID_W-1:0];
   assign slot_diff = hash_ff - mul_p[MOD_W-1:0];

   assign slot_free  = !rd_entry.used;
   assign key_hit    = (rd_entry.key == id_ff);
   assign last_probe = (cnt_ff == LAST_SLOT);
   assign probe_end  = slot_free || (action_ff == lpht_pkg::ACT_LOOKUP && key_hit) || last_probe;
   assign pos_next   = (pos_ff == LAST_SLOT) ? '0 : SLOT_W'(pos_ff + 1'b1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpht_pkg::S_CLEAR: begin
            if (pos_ff == LAST_SLOT) begin
               state_in = lpht_pkg::S_IDLE;
            end
         end
         lpht_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = lpht_pkg::S_HASH_MUL;
            end
         end
         lpht_pkg::S_HASH_MUL: begin
            state_in = lpht_pkg::S_HASH_SUB;
         end
         lpht_pkg::S_HASH_SUB: begin
            state_in = lpht_pkg::S_SLOT_MUL;
         end
         lpht_pkg::S_SLOT_MUL: begin
            state_in = lpht_pkg::S_SLOT_SUB;
         end
         lpht_pkg::S_SLOT_SUB: begin
            state_in = lpht_pkg::S_PROBE;
         end
         lpht_pkg::S_PROBE: begin
            if (probe_end) begin
               state_in = lpht_pkg::S_DONE;
            end
         end
         lpht_pkg::S_DONE: begin
            if (rsp_tready) begin
               state_in = lpht_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lpht_pkg::S_CLEAR;
         end
      endcase
   end

   always_comb begin
      action_in     = action_ff;
      id_in         = id_ff;
      name_in       = name_ff;
      course_in     = course_ff;
      quo_in        = quo_ff;
      hash_in       = hash_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_id_in     = res_id_ff;
      res_name_in   = res_name_ff;
      res_course_in = res_course_ff;
      ram_we        = 1'b0;
      ram_wdata     = '0;
      unique case (state_ff)
         lpht_pkg::S_CLEAR: begin
            ram_we = 1'b1;
            pos_in = pos_next;
         end
         lpht_pkg::S_IDLE: begin
            if (req_tvalid) begin
               action_in = lpht_pkg::action_type'(req_tuser);
               id_in     = req_tdata[ID_W-1:0];
               name_in   = req_tdata[ID_W +: PAY_W];
               course_in = req_tdata[ID_W+PAY_W +: PAY_W];
            end
         end
         lpht_pkg::S_HASH_MUL: begin
            quo_in = mul_p[HASH_SHIFT +: QUO_W];
         end
         lpht_pkg::S_HASH_SUB: begin
            hash_in = hash_diff[MOD_W-1:0];
         end
         lpht_pkg::S_SLOT_MUL: begin
            quo_in = mul_p[SLOT_SHIFT +: QUO_W];
         end
         lpht_pkg::S_SLOT_SUB: begin
            pos_in = slot_diff[SLOT_W-1:0];
            cnt_in = '0;
         end
         lpht_pkg::S_PROBE: begin
            priority if (slot_free) begin
               if (action_ff == lpht_pkg::ACT_INSERT) begin
                  ram_we           = 1'b1;
                  ram_wdata.used   = 1'b1;
                  ram_wdata.key    = id_ff;
                  ram_wdata.name   = name_ff;
                  ram_wdata.course = course_ff;
                  res_status_in    = lpht_pkg::STS_INSERTED;
                  res_slot_in      = lpht_pkg::SLOT_OUT_W'(pos_ff);
                  res_id_in        = id_ff;
                  res_name_in      = name_ff;
                  res_course_in    = course_ff;
               end else begin
                  res_status_in = lpht_pkg::STS_NOT_FOUND;
                  res_slot_in   = '0;
                  res_id_in     = '0;
                  res_name_in   = '0;
                  res_course_in = '0;
               end
            end else if (action_ff == lpht_pkg::ACT_LOOKUP && key_hit) begin
               res_status_in = lpht_pkg::STS_FOUND;
               res_slot_in   = lpht_pkg::SLOT_OUT_W'(pos_ff);
               res_id_in     = rd_entry.key;
               res_name_in   = rd_entry.name;
               res_course_in = rd_entry.course;
            end else if (last_probe) begin
               res_status_in = (action_ff == lpht_pkg::ACT_INSERT) ? lpht_pkg::STS_FULL
                                                                   : lpht_pkg::STS_NOT_FOUND;
               res_slot_in   = '0;
               res_id_in     = '0;
               res_name_in   = '0;
               res_course_in = '0;
            end else begin
               pos_in = pos_next;
               cnt_in = SLOT_W'(cnt_ff + 1'b1);
            end
         end
         lpht_pkg::S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpht_pkg::S_CLEAR;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      id_ff         <= id_in;
      name_ff       <= name_in;
      course_ff     <= course_in;
      quo_ff        <= quo_in;
      hash_ff       <= hash_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_id_ff     <= res_id_in;
      res_name_ff   <= res_name_in;
      res_course_ff <= res_course_in;
   end

   assign req_tready = (state_ff == lpht_pkg::S_IDLE);
   assign rsp_tvalid = (state_ff == lpht_pkg::S_DONE);
   assign rsp_tuser  = res_status_ff;
   assign rsp_tdata  = {{lpht_pkg::RSP_PAD_W{1'b0}}, res_course_ff, res_name_ff,
                        res_id_ff, res_slot_ff};

   assign req_take = req_tvalid && req_tready;
   assign in_hash  = (state_ff == lpht_pkg::S_HASH_MUL);
   assign in_probe = (state_ff == lpht_pkg::S_PROBE);

   `ASSERT_NEXT(a_take_hash, clock, reset, req_take, in_hash, "hash did not start")
   `ASSERT_IMPLIES(a_write_free, clock, reset, ram_we && in_probe, slot_free, "write to used slot")
   `ASSERT_IMPLIES(a_probe_pass, clock, reset, in_probe, cnt_ff <= LAST_SLOT, "probe past one pass")

endmodule

FILE: sim/tb_linear_probe_hash_table_unit.sv
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_unit;
   import lpht_pkg::*;

   localparam int SLOTS        = TABLE_SLOTS_DEF;
   localparam int RANDOM_ITEMS = 930;
   localparam int TAIL_ITEMS   = 150;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic              drain_first;
      action_type        action;
      logic [ID_W-1:0]   id;
      logic [PAY_W-1:0]  name;
      logic [PAY_W-1:0]  course;
   } table_request;

   typedef struct packed {
      status_type             status;
      logic [SLOT_OUT_W-1:0]  slot;
      logic [ID_W-1:0]        id;
      logic [PAY_W-1:0]       name;
      logic [PAY_W-1:0]       course;
   } table_result;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [1:0]            rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   table_request pending_requests[$];
   table_result  results_due[$];
   logic [ID_W-1:0] stored_ids[$];

   logic             model_used[SLOTS];
   logic [ID_W-1:0]  model_key[SLOTS];
   logic [PAY_W-1:0] model_name[SLOTS];
   logic [PAY_W-1:0] model_course[SLOTS];

   table_request req_current;
   table_result  predicted;
   int           send_idle = 0;
   int           recv_stall = 0;
   int           error_count = 0;
   int           cycle_count = 0;

   linear_probe_hash_table_unit #(.TABLE_SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // probe from the home slot, at most one pass
   task automatic table_step(input table_request r, output table_result res);
      int unsigned pos;
      bit          hit;
      pos = (int'(r.id) % ID_MODULUS) % SLOTS;
      hit = 1'b0;
      res = '{STS_FULL, '0, '0, '0, '0};
      if (r.action == ACT_INSERT) begin
         for (int n = 0; n < SLOTS && !hit; n++) begin
            if (!model_used[pos]) begin
               model_used[pos]   = 1'b1;
               model_key[pos]    = r.id;
               model_name[pos]   = r.name;
               model_course[pos] = r.course;
               res = '{STS_INSERTED, pos[SLOT_OUT_W-1:0], r.id, r.name, r.course};
               hit = 1'b1;
            end else begin
               pos = (pos + 1) % SLOTS;
            end
         end
      end else begin
         res = '{STS_NOT_FOUND, '0, '0, '0, '0};
         for (int n = 0; n < SLOTS && !hit; n++) begin
            if (!model_used[pos]) begin
               hit = 1'b1;
            end else if (model_key[pos] == r.id) begin
               res = '{STS_FOUND, pos[SLOT_OUT_W-1:0], model_key[pos], model_name[pos],
                       model_course[pos]};
               hit = 1'b1;
            end else begin
               pos = (pos + 1) % SLOTS;
            end
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [PAY_W-1:0] got,
                                  input logic [PAY_W-1:0] want);
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic add_request(input action_type act, input logic [ID_W-1:0] id,
                              input logic [PAY_W-1:0] nm, input logic [PAY_W-1:0] cs,
                              input logic drain);
      pending_requests.push_back('{drain, act, id, nm, cs});
      if (act == ACT_INSERT) stored_ids.push_back(id);
   endtask

   function automatic logic [ID_W-1:0] random_id();
      logic [ID_W-1:0] base;
      case ($urandom_range(0, 9))
         0, 1, 2: random_id = ID_W'($urandom);
         3, 4: random_id = ID_W'($urandom_range(0, 1999));
         5, 6, 7: random_id = (stored_ids.size() == 0) ? ID_W'($urandom)
                            : stored_ids[$urandom_range(0, stored_ids.size() - 1)];
         default: begin
            base = (stored_ids.size() == 0) ? '0
                 : stored_ids[$urandom_range(0, stored_ids.size() - 1)];
            random_id = base + ID_W'(ID_MODULUS * $urandom_range(1, 1000));
         end
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            table_step(req_current, predicted);
            results_due.push_back(predicted);
         end
         if (!req_tvalid || req_tready) begin
            if (send_idle > 0) begin
               send_idle--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() == 0 ||
                         (pending_requests[0].drain_first && results_due.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
               send_idle = $urandom_range(0, 7);
               req_tvalid <= 1'b0;
            end else begin
               req_current = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= req_current.action;
               req_tdata  <= {1'b0, req_current.course, req_current.name, req_current.id};
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      table_result want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata[PAY_W-1:0], '0);
            end else begin
               want = results_due.pop_front();
               if (rsp_tuser != want.status)
                  report_mismatch("status", PAY_W'(rsp_tuser), PAY_W'(want.status));
               if (rsp_tdata[4:0] != want.slot)
                  report_mismatch("slot_index", PAY_W'(rsp_tdata[4:0]), PAY_W'(want.slot));
               if (rsp_tdata[35:5] != want.id)
                  report_mismatch("found_id", PAY_W'(rsp_tdata[35:5]), PAY_W'(want.id));
               if (rsp_tdata[99:36] != want.name)
                  report_mismatch("found_name", rsp_tdata[99:36], want.name);
               if (rsp_tdata[163:100] != want.course)
                  report_mismatch("found_course", rsp_tdata[163:100], want.course);
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (pending_requests.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
            recv_stall = $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      action_type act;
      for (int s = 0; s < SLOTS; s++) model_used[s] = 1'b0;

      // empty table, extremes, collisions, duplicates, wrap at the table end
      add_request(ACT_LOOKUP, '0, '0, '0, 1'b0);
      add_request(ACT_INSERT, '0, '0, '0, 1'b0);
      add_request(ACT_INSERT, '1, '1, '1, 1'b0);
      add_request(ACT_INSERT, 31'd1000, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
      add_request(ACT_INSERT, '0, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
      add_request(ACT_LOOKUP, '0, '1, '1, 1'b0);
      add_request(ACT_LOOKUP, 31'd1000, '0, '0, 1'b0);
      add_request(ACT_LOOKUP, '1, '0, '0, 1'b0);
      add_request(ACT_LOOKUP, 31'd2000, '0, '0, 1'b0);
      add_request(ACT_INSERT, 31'd16, 64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888, 1'b0);
      add_request(ACT_INSERT, 31'd33, 64'h9999_aaaa_bbbb_cccc, 64'hdddd_eeee_ffff_0000, 1'b0);
      add_request(ACT_LOOKUP, 31'd33, '0, '0, 1'b0);
      add_request(ACT_LOOKUP, 31'd50, '0, '0, 1'b0);
      add_request(ACT_INSERT, 31'h2aaa_aaaa, '1, '0, 1'b0);
      add_request(ACT_INSERT, 31'h5555_5555, '0, '1, 1'b0);
      add_request(ACT_LOOKUP, 31'h5555_5555, '0, '0, 1'b0);

      // table fills early; afterwards inserts report full and misses take a full pass
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         act = ($urandom_range(0, 5) == 0) ? ACT_INSERT : ACT_LOOKUP;
         add_request(act, random_id(), {$urandom, $urandom}, {$urandom, $urandom},
                     i == 0 || $urandom_range(0, 199) == 0);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_tvalid) @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
